// ===== rtl/gpiox_pkg.sv =====
`default_nettype none

package gpiox_pkg;

  localparam int PinsPerPort     = 8;
  localparam int MaxPorts        = 4;
  localparam int NumPortsDefault = 4;
  localparam int PadWidth        = 32;
  localparam int NumLines        = 3;
  localparam int CfgDataWidth    = 3;

  typedef logic [3:0] func_t;

  localparam func_t FUNC_NONE        = 4'd0;
  localparam func_t FUNC_PIN_DIR     = 4'd1;
  localparam func_t FUNC_PORT_DIR    = 4'd2;
  localparam func_t FUNC_SET_PIN     = 4'd3;
  localparam func_t FUNC_CLEAR_PIN   = 4'd4;
  localparam func_t FUNC_TOGGLE_PIN  = 4'd5;
  localparam func_t FUNC_WRITE_PORT  = 4'd6;
  localparam func_t FUNC_SET_MASK    = 4'd7;
  localparam func_t FUNC_CLEAR_MASK  = 4'd8;
  localparam func_t FUNC_READ_PIN    = 4'd9;
  localparam func_t FUNC_READ_PORT   = 4'd10;
  localparam func_t FUNC_CLEAR_FLAG  = 4'd11;

  typedef logic [1:0] sense_t;

  localparam sense_t SENSE_LOW    = 2'd0;
  localparam sense_t SENSE_CHANGE = 2'd1;
  localparam sense_t SENSE_FALL   = 2'd2;
  localparam sense_t SENSE_RISE   = 2'd3;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_INT0_SENSE  = 2'd0;
  localparam cfg_idx_t CFG_INT1_SENSE  = 2'd1;
  localparam cfg_idx_t CFG_INT2_RISING = 2'd2;
  localparam cfg_idx_t CFG_INT_ENABLE  = 2'd3;

  typedef struct packed {
    func_t                func;
    logic [4:0]           pin_index;
    logic [1:0]           port_select;
    logic [7:0]           bit_mask;
    logic                 direction;
    logic [PadWidth-1:0]  pad_levels;
    logic [NumLines-1:0]  int_lines;
    logic [1:0]           int_select;
  } item_t;

  typedef struct packed {
    sense_t               int0_sense;
    sense_t               int1_sense;
    logic                 int2_rising;
    logic [NumLines-1:0]  int_enable_mask;
  } cfg_t;

  function automatic int eff_pins(input int num_ports);
    eff_pins = ((num_ports < MaxPorts) ? num_ports : MaxPorts) * PinsPerPort;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gpiox_in_if.sv =====
`default_nettype none

interface gpiox_in_if;
  logic                               valid;
  logic                               ready;
  gpiox_pkg::func_t                   func;
  logic [4:0]                         pin_index;
  logic [1:0]                         port_select;
  logic [7:0]                         bit_mask;
  logic                               direction;
  logic [gpiox_pkg::PadWidth-1:0]     pad_levels;
  logic [gpiox_pkg::NumLines-1:0]     int_lines;
  logic [1:0]                         int_select;

  modport source (
    output valid, func, pin_index, port_select, bit_mask, direction, pad_levels,
           int_lines, int_select,
    input  ready
  );
  modport sink (
    input  valid, func, pin_index, port_select, bit_mask, direction, pad_levels,
           int_lines, int_select,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/gpiox_out_if.sv =====
`default_nettype none

interface gpiox_out_if;
  logic                               valid;
  logic                               ready;
  logic [7:0]                         read_data;
  logic [gpiox_pkg::PadWidth-1:0]     drive_levels;
  logic [gpiox_pkg::PadWidth-1:0]     drive_enables;
  logic [gpiox_pkg::NumLines-1:0]     int_flags_out;
  logic [gpiox_pkg::NumLines-1:0]     int_request;

  modport source (
    output valid, read_data, drive_levels, drive_enables, int_flags_out, int_request,
    input  ready
  );
  modport sink (
    input  valid, read_data, drive_levels, drive_enables, int_flags_out, int_request,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/gpiox_pins.sv =====
`default_nettype none

module gpiox_pins #(
  parameter int NumPorts = gpiox_pkg::NumPortsDefault
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire gpiox_pkg::item_t                      item,
  output logic [gpiox_pkg::eff_pins(NumPorts)-1:0]   dir_nxt_o,
  output logic [gpiox_pkg::eff_pins(NumPorts)-1:0]   out_nxt_o,
  output logic [7:0]                                 read_data_o
);

  localparam int NumPins  = gpiox_pkg::eff_pins(NumPorts);
  localparam int EffPorts = NumPins / gpiox_pkg::PinsPerPort;

  logic [NumPins-1:0]             dir_r;
  logic [NumPins-1:0]             out_r;
  logic                           pin_ok;
  logic                           port_ok;
  logic [4:0]                     pshift;
  logic [gpiox_pkg::PadWidth-1:0] pin_bit32;
  logic [gpiox_pkg::PadWidth-1:0] pmask32;
  logic [gpiox_pkg::PadWidth-1:0] pfull32;
  logic [gpiox_pkg::PadWidth-1:0] pad_shift;
  logic [NumPins-1:0]             pin_bit;
  logic [NumPins-1:0]             pmask;
  logic [NumPins-1:0]             pfull;

  assign pin_ok    = {1'b0, item.pin_index[4:3]} < 3'(EffPorts);
  assign port_ok   = {1'b0, item.port_select} < 3'(EffPorts);
  assign pshift    = {item.port_select, 3'b000};
  assign pin_bit32 = 32'd1 << item.pin_index;
  assign pmask32   = {24'd0, item.bit_mask} << pshift;
  assign pfull32   = 32'h0000_00ff << pshift;
  assign pad_shift = item.pad_levels >> pshift;
  assign pin_bit   = pin_bit32[NumPins-1:0];
  assign pmask     = pmask32[NumPins-1:0];
  assign pfull     = pfull32[NumPins-1:0];

  always_comb begin
    dir_nxt_o   = dir_r;
    out_nxt_o   = out_r;
    read_data_o = 8'd0;
    case (item.func)
      gpiox_pkg::FUNC_PIN_DIR: begin
        if (pin_ok) begin
          dir_nxt_o = item.direction ? (dir_r | pin_bit) : (dir_r & ~pin_bit);
        end
      end
      gpiox_pkg::FUNC_PORT_DIR: begin
        if (port_ok) begin
          dir_nxt_o = item.direction ? (dir_r | pmask) : (dir_r & ~pmask);
        end
      end
      gpiox_pkg::FUNC_SET_PIN: begin
        if (pin_ok) out_nxt_o = out_r | pin_bit;
      end
      gpiox_pkg::FUNC_CLEAR_PIN: begin
        if (pin_ok) out_nxt_o = out_r & ~pin_bit;
      end
      gpiox_pkg::FUNC_TOGGLE_PIN: begin
        if (pin_ok) out_nxt_o = out_r ^ pin_bit;
      end
      gpiox_pkg::FUNC_WRITE_PORT: begin
        if (port_ok) out_nxt_o = (out_r & ~pfull) | pmask;
      end
      gpiox_pkg::FUNC_SET_MASK: begin
        if (port_ok) out_nxt_o = out_r | pmask;
      end
      gpiox_pkg::FUNC_CLEAR_MASK: begin
        if (port_ok) out_nxt_o = out_r & ~pmask;
      end
      gpiox_pkg::FUNC_READ_PIN: begin
        if (pin_ok) read_data_o = {7'd0, item.pad_levels[item.pin_index]};
      end
      gpiox_pkg::FUNC_READ_PORT: begin
        if (port_ok) read_data_o = pad_shift[7:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= '0;
      out_r <= '0;
    end else if (adv) begin
      dir_r <= dir_nxt_o;
      out_r <= out_nxt_o;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpiox_irq.sv =====
`default_nettype none

module gpiox_irq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire gpiox_pkg::item_t                 item,
  input  wire gpiox_pkg::cfg_t                  cfg,
  output logic [gpiox_pkg::NumLines-1:0]        flags_nxt_o,
  output logic [gpiox_pkg::NumLines-1:0]        req_o
);

  localparam int NumLines = gpiox_pkg::NumLines;

  logic [NumLines-1:0]     prev_r;
  logic [NumLines-1:0]     flags_r;
  logic [NumLines-1:0]     detect;
  logic [NumLines-1:0]     low_req;
  logic [NumLines-1:0]     clr;
  gpiox_pkg::sense_t       mode [NumLines];

  assign mode[0] = cfg.int0_sense;
  assign mode[1] = cfg.int1_sense;
  assign mode[2] = cfg.int2_rising ? gpiox_pkg::SENSE_RISE : gpiox_pkg::SENSE_FALL;

  always_comb begin
    detect  = '0;
    low_req = '0;
    for (int n = 0; n < NumLines; n++) begin
      case (mode[n])
        gpiox_pkg::SENSE_LOW:    low_req[n] = !item.int_lines[n];
        gpiox_pkg::SENSE_CHANGE: detect[n]  = item.int_lines[n] != prev_r[n];
        gpiox_pkg::SENSE_FALL:   detect[n]  = prev_r[n] && !item.int_lines[n];
        gpiox_pkg::SENSE_RISE:   detect[n]  = !prev_r[n] && item.int_lines[n];
        default:                 detect[n]  = 1'b0;
      endcase
    end
  end

  always_comb begin
    clr = '0;
    if (item.func == gpiox_pkg::FUNC_CLEAR_FLAG && item.int_select < 2'(NumLines)) begin
      clr = NumLines'(1) << item.int_select;
    end
  end

  assign flags_nxt_o = (flags_r & ~clr) | detect;
  assign req_o       = cfg.int_enable_mask & (flags_nxt_o | low_req);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '1;
      flags_r <= '0;
    end else if (adv) begin
      prev_r  <= item.int_lines;
      flags_r <= flags_nxt_o;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gpio_ports_with_external_interrupts.sv =====
// GPIO block with up to four ports of eight pins and three external interrupt lines. Each
// item carries one operation selected by func together with a sample of the pads and the
// interrupt lines, and returns exactly one result item with the pad read value, the output
// and direction bits after the operation, the edge flags and the interrupt requests. An item
// is registered on entry and its result is registered on exit, and a new item is taken
// every clock while the result side keeps up; the single read-modify-write of the pin and
// flag registers between those two registers sets that rate.
// Pins of ports at or beyond NUM_PORTS ignore writes and read as zero.
`default_nettype none

module gpio_ports_with_external_interrupts #(
  parameter int NUM_PORTS = gpiox_pkg::NumPortsDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  gpiox_in_if.sink                               in_ch,
  gpiox_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire gpiox_pkg::cfg_idx_t               cfg_index,
  input  wire logic [gpiox_pkg::CfgDataWidth-1:0] cfg_wdata
);

  localparam int NumPins  = gpiox_pkg::eff_pins(NUM_PORTS);
  localparam int PadWidth = gpiox_pkg::PadWidth;
  localparam int NumLines = gpiox_pkg::NumLines;

  logic                   s1_v_r;
  gpiox_pkg::item_t       s1_item_r;
  logic                   out_v_r;
  logic [7:0]             rd_r;
  logic [PadWidth-1:0]    drv_r;
  logic [PadWidth-1:0]    en_r;
  logic [NumLines-1:0]    flags_r;
  logic [NumLines-1:0]    req_r;
  gpiox_pkg::cfg_t        cfg_r;
  logic                   adv;
  logic                   in_acc;
  logic [NumPins-1:0]     dir_nxt;
  logic [NumPins-1:0]     out_nxt;
  logic [7:0]             rd_nxt;
  logic [NumLines-1:0]    flags_nxt;
  logic [NumLines-1:0]    req_nxt;
  logic [PadWidth-1:0]    drv_pad;
  logic [PadWidth-1:0]    en_pad;

  assign adv          = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.func        <= in_ch.func;
      s1_item_r.pin_index   <= in_ch.pin_index;
      s1_item_r.port_select <= in_ch.port_select;
      s1_item_r.bit_mask    <= in_ch.bit_mask;
      s1_item_r.direction   <= in_ch.direction;
      s1_item_r.pad_levels  <= in_ch.pad_levels;
      s1_item_r.int_lines   <= in_ch.int_lines;
      s1_item_r.int_select  <= in_ch.int_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gpiox_pkg::CFG_INT0_SENSE:  cfg_r.int0_sense      <= cfg_wdata[1:0];
        gpiox_pkg::CFG_INT1_SENSE:  cfg_r.int1_sense      <= cfg_wdata[1:0];
        gpiox_pkg::CFG_INT2_RISING: cfg_r.int2_rising     <= cfg_wdata[0];
        gpiox_pkg::CFG_INT_ENABLE:  cfg_r.int_enable_mask <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  gpiox_pins #(
    .NumPorts (NUM_PORTS)
  ) u_pins (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .item        (s1_item_r),
    .dir_nxt_o   (dir_nxt),
    .out_nxt_o   (out_nxt),
    .read_data_o (rd_nxt)
  );

  gpiox_irq u_irq (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .item        (s1_item_r),
    .cfg         (cfg_r),
    .flags_nxt_o (flags_nxt),
    .req_o       (req_nxt)
  );

  always_comb begin
    drv_pad                = '0;
    en_pad                 = '0;
    drv_pad[NumPins-1:0]   = out_nxt;
    en_pad[NumPins-1:0]    = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r    <= rd_nxt;
      drv_r   <= drv_pad;
      en_r    <= en_pad;
      flags_r <= flags_nxt;
      req_r   <= req_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.read_data     = rd_r;
  assign out_ch.drive_levels  = drv_r;
  assign out_ch.drive_enables = en_r;
  assign out_ch.int_flags_out = flags_r;
  assign out_ch.int_request   = req_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("A finished item did not reach the result register.");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("A stalled item in the input register was lost or altered.");

  a_missing_ports_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (((drv_r >> NumPins) == '0) && ((en_r >> NumPins) == '0)))
    else $error("A pin of a missing port is driven.");

endmodule

`default_nettype wire
